// ----- src/mfd_pkg.sv -----
// Shared types and constants of the motor feedback frame decoder.
`default_nettype none
package mfd_pkg;

   localparam int FRAC_BITS = 16;

   // Operand widths of the shared serial multiply-divide unit.
   localparam int MD_A_W   = 23;
   localparam int MD_B_W   = 20;
   localparam int MD_D_W   = 16;
   localparam int MD_P_W   = MD_A_W + MD_B_W;
   localparam int MD_Q_W   = MD_P_W + 1;
   localparam int MD_CNT_W = $clog2(MD_P_W);

   // Pi rounded to the fixed-point grid.
   localparam logic signed [24:0] PI_FX     = 25'sd205887;
   localparam logic signed [24:0] TWO_PI_FX = 25'sd411774;

   localparam logic [MD_A_W-1:0] VEL_SCALE = MD_A_W'(90 * (1 << FRAC_BITS));
   localparam logic [MD_A_W-1:0] TOR_SCALE = MD_A_W'(80 * (1 << FRAC_BITS));
   localparam logic signed [22:0] VEL_BASE = 23'(-45 * (1 << FRAC_BITS));
   localparam logic signed [22:0] TOR_BASE = 23'(-40 * (1 << FRAC_BITS));
   localparam logic [MD_B_W-1:0] DEG_NUM   = MD_B_W'(572958);
   localparam logic [MD_D_W-1:0] DEG_DEN   = MD_D_W'(10000);
   localparam logic [MD_D_W-1:0] POS_DEN   = MD_D_W'(65535);
   localparam logic [MD_D_W-1:0] RAW12_DEN = MD_D_W'(4095);
   localparam logic signed [25:0] HALF_TURN_FX = 26'(180 * (1 << FRAC_BITS));
   localparam logic signed [15:0] TURN_LIMIT = 16'sd32767;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_POS_MIN     = 2'd0;
   localparam logic [1:0] CSR_POS_MAX     = 2'd1;
   localparam logic [1:0] CSR_ZERO_OFFSET = 2'd2;

   // One operation for the serial unit: floor(sign * a_mag * b / d).
   typedef struct packed {
      logic [MD_A_W-1:0] a_mag;
      logic              a_neg;
      logic [MD_B_W-1:0] b;
      logic [MD_D_W-1:0] d;
   } mfd_op_type;

endpackage
`default_nettype wire

// ----- src/mfd_muldiv.sv -----
// Bit-serial multiply followed by a bit-serial floor division by the given divisor.
`default_nettype none
module mfd_muldiv (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   input  mfd_pkg::mfd_op_type                  op,
   output logic                                 done,
   output logic signed [mfd_pkg::MD_Q_W-1:0]    quot
);
   import mfd_pkg::*;

   localparam logic [2:0] U_IDLE = 3'd0;
   localparam logic [2:0] U_MUL  = 3'd1;
   localparam logic [2:0] U_BIAS = 3'd2;
   localparam logic [2:0] U_DIV  = 3'd3;
   localparam logic [2:0] U_DONE = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [MD_CNT_W-1:0] cnt_ff, cnt_in;
   logic [MD_P_W-1:0]   acc_ff, acc_in;
   logic [MD_A_W-1:0]   a_ff, a_in;
   logic [MD_B_W-1:0]   b_ff, b_in;
   logic [MD_D_W-1:0]   d_ff, d_in;
   logic                neg_ff, neg_in;
   logic [MD_D_W:0]     rem_ff, rem_in;
   logic [MD_D_W:0]     trial;
   logic                qbit;

   assign trial = {rem_ff[MD_D_W-1:0], acc_ff[MD_P_W-1]};
   assign qbit  = (trial >= {1'b0, d_ff});

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      d_in     = d_ff;
      neg_in   = neg_ff;
      rem_in   = rem_ff;
      case (state_ff)
         U_IDLE, U_DONE: begin
            // A new operation may start in the cycle that the last one finishes.
            state_in = U_IDLE;
            if (start) begin
               a_in     = op.a_mag;
               b_in     = op.b;
               d_in     = op.d;
               neg_in   = op.a_neg;
               acc_in   = '0;
               cnt_in   = MD_CNT_W'(MD_B_W - 1);
               state_in = U_MUL;
            end
         end
         U_MUL: begin
            // Multiplier bits are taken from the top down.
            acc_in = {acc_ff[MD_P_W-2:0], 1'b0}
                   + (b_ff[MD_B_W-1] ? MD_P_W'(a_ff) : '0);
            b_in   = {b_ff[MD_B_W-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = U_BIAS;
            end
         end
         U_BIAS: begin
            // A negative quotient rounds down, so its magnitude rounds up.
            if (neg_ff) begin
               acc_in = acc_ff + MD_P_W'(d_ff - 1'b1);
            end
            rem_in   = '0;
            cnt_in   = MD_CNT_W'(MD_P_W - 1);
            state_in = U_DIV;
         end
         U_DIV: begin
            rem_in = qbit ? (trial - {1'b0, d_ff}) : trial;
            acc_in = {acc_ff[MD_P_W-2:0], qbit};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = U_DONE;
            end
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
      rem_ff <= rem_in;
   end

   assign done = (state_ff == U_DONE);
   assign quot = neg_ff ? -$signed({1'b0, acc_ff}) : $signed({1'b0, acc_ff});

endmodule
`default_nettype wire

// ----- src/motor_feedback_frame_decoder.sv -----
// Top level of the motor feedback frame decoder.
//
// One eight-byte feedback frame goes in per transfer and one decoded result
// comes out. Each frame runs four operations through a single bit-serial
// multiply-divide unit (position, velocity, torque, degrees), with angle
// wrapping after the position and bookkeeping at the end; the result is
// written to the output register only once that register is free.
// A finished result waits in the output register while the next frame is
// taken in.
`default_nettype none
module motor_feedback_frame_decoder (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // byte_0, byte_1, ... byte_7 from bit 0 up
   input  wire  [63:0]  req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // status_code, position_rad, velocity, torque, stage_temp, rotor_temp,
   // angle_deg, turn_count, total_angle_deg from bit 0 up, one pad bit
   output logic [167:0] rsp_tdata,
   input  wire          csr_wen,
   input  wire  [1:0]   csr_index,
   input  wire  [21:0]  csr_wdata
);
   import mfd_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_POS  = 3'd1;
   localparam logic [2:0] S_WRAP = 3'd2;
   localparam logic [2:0] S_VEL  = 3'd3;
   localparam logic [2:0] S_TOR  = 3'd4;
   localparam logic [2:0] S_ANG  = 3'd5;
   localparam logic [2:0] S_TOT  = 3'd6;

   logic signed [21:0] pos_min_ff, pos_max_ff;
   logic signed [19:0] zero_offset_ff;

   logic [2:0]         state_ff, state_in;
   logic [63:0]        frame_ff, frame_in;
   logic [3:0]         status_ff, status_in;
   logic signed [24:0] pos_ff, pos_in;
   logic signed [22:0] vel_ff, vel_in;
   logic signed [22:0] tor_ff, tor_in;
   logic signed [24:0] ang_ff, ang_in;
   logic signed [24:0] last_angle_ff, last_angle_in;
   logic signed [15:0] turns_ff, turns_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [167:0]       rsp_data_ff, rsp_data_in;

   logic               md_start;
   mfd_op_type         md_op;
   logic               md_done;
   logic signed [MD_Q_W-1:0] md_quot;

   logic signed [22:0] span;
   logic [11:0]        vraw, traw;
   logic signed [25:0] diff;
   logic               out_free;

   mfd_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (md_start),
      .op    (md_op),
      .done  (md_done),
      .quot  (md_quot)
   );

   assign span = 23'(pos_max_ff) - 23'(pos_min_ff);
   assign vraw = {frame_ff[31:24], frame_ff[39:36]};
   assign traw = {frame_ff[35:32], frame_ff[47:40]};
   assign diff = 26'(last_angle_ff) - 26'(ang_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      frame_in      = frame_ff;
      status_in     = status_ff;
      pos_in        = pos_ff;
      vel_in        = vel_ff;
      tor_in        = tor_ff;
      ang_in        = ang_ff;
      last_angle_in = last_angle_ff;
      turns_in      = turns_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      md_start      = 1'b0;
      md_op         = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               frame_in = req_tdata;
               // Listed nibbles map to codes; the rest keep the last code.
               case (req_tdata[7:4])
                  4'd0:    status_in = 4'd0;
                  4'd1:    status_in = 4'd1;
                  4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14:
                           status_in = req_tdata[7:4] - 4'd6;
                  default: status_in = status_ff;
               endcase
               md_start  = 1'b1;
               md_op.a_mag = span[22] ? MD_A_W'(-span) : MD_A_W'(span);
               md_op.a_neg = span[22];
               md_op.b     = MD_B_W'({req_tdata[15:8], req_tdata[23:16]});
               md_op.d     = POS_DEN;
               state_in  = S_POS;
            end
         end
         S_POS: begin
            if (md_done) begin
               pos_in   = 25'(pos_min_ff) + 25'(md_quot) + 25'(zero_offset_ff);
               state_in = S_WRAP;
            end
         end
         S_WRAP: begin
            if (pos_ff > PI_FX) begin
               pos_in = pos_ff - TWO_PI_FX;
            end else if (pos_ff < -PI_FX) begin
               pos_in = pos_ff + TWO_PI_FX;
            end else begin
               md_start    = 1'b1;
               md_op.a_mag = VEL_SCALE;
               md_op.b     = MD_B_W'(vraw);
               md_op.d     = RAW12_DEN;
               state_in    = S_VEL;
            end
         end
         S_VEL: begin
            if (md_done) begin
               vel_in      = VEL_BASE + 23'(md_quot);
               md_start    = 1'b1;
               md_op.a_mag = TOR_SCALE;
               md_op.b     = MD_B_W'(traw);
               md_op.d     = RAW12_DEN;
               state_in    = S_TOR;
            end
         end
         S_TOR: begin
            if (md_done) begin
               tor_in      = TOR_BASE + 23'(md_quot);
               md_start    = 1'b1;
               md_op.a_mag = pos_ff[24] ? MD_A_W'(-pos_ff) : MD_A_W'(pos_ff);
               md_op.a_neg = pos_ff[24];
               md_op.b     = DEG_NUM;
               md_op.d     = DEG_DEN;
               state_in    = S_ANG;
            end
         end
         S_ANG: begin
            if (md_done) begin
               ang_in   = 25'(md_quot);
               state_in = S_TOT;
            end
         end
         S_TOT: begin
            if (out_free) begin
               if (diff > HALF_TURN_FX && turns_ff < TURN_LIMIT) begin
                  turns_in = turns_ff + 16'sd1;
               end else if (diff < -HALF_TURN_FX && turns_ff > -TURN_LIMIT) begin
                  turns_in = turns_ff - 16'sd1;
               end
               last_angle_in = ang_ff;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The turn count update and the total use the updated count.
   // 360 turns scale is 2^24 + 2^22 + 2^21 + 2^19 in fixed point.
   logic signed [40:0] total_next;
   logic signed [40:0] turns_next_wide;
   logic [167:0]       rsp_data_in_pack;
   assign turns_next_wide = 41'(turns_in);
   assign total_next = (turns_next_wide <<< 24) + (turns_next_wide <<< 22)
                     + (turns_next_wide <<< 21) + (turns_next_wide <<< 19)
                     + 41'(ang_ff);

   always_comb begin
      rsp_data_in_pack = {1'b0, total_next, turns_in, ang_ff, frame_ff[63:56],
                          frame_ff[55:48], tor_ff, vel_ff, pos_ff[18:0], status_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         status_ff      <= 4'd0;
         last_angle_ff  <= '0;
         turns_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         pos_min_ff     <= -22'(PI_FX);
         pos_max_ff     <= 22'(PI_FX);
         zero_offset_ff <= '0;
      end else begin
         state_ff      <= state_in;
         status_ff     <= status_in;
         last_angle_ff <= last_angle_in;
         turns_ff      <= turns_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wen) begin
            case (csr_index)
               CSR_POS_MIN:     pos_min_ff     <= csr_wdata;
               CSR_POS_MAX:     pos_max_ff     <= csr_wdata;
               CSR_ZERO_OFFSET: zero_offset_ff <= csr_wdata[19:0];
               default:         ;
            endcase
         end
      end
      frame_ff <= frame_in;
      pos_ff   <= pos_in;
      vel_ff   <= vel_in;
      tor_ff   <= tor_in;
      ang_ff   <= ang_in;
      if (state_ff == S_TOT && out_free) begin
         rsp_data_ff <= rsp_data_in_pack;
      end else begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire
